FILE: rtl/clq_pkg.sv
// shared types and constants for the coalescing lifo job queue
// no dependencies; used by clq_ctrl, clq_dp and coalescing_lifo_job_queue
`default_nettype none

package clq_pkg;

    localparam int PAGE_W     = 6;
    localparam int KIND_W     = 2;
    localparam int ROT_W      = 2;
    localparam int SIZE_W     = 16;
    localparam int MODE_W     = 2;
    localparam int SETTINGS_W = 32;
    localparam int COUNT_W    = 7;

    localparam logic [KIND_W-1:0] KIND_RENDER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEANUP = 2'd3;

    typedef enum logic [2:0] {
        CMD_ADD        = 3'd0,
        CMD_TAKE       = 3'd1,
        CMD_FINISH     = 3'd2,
        CMD_REMOVE_ALL = 3'd3,
        CMD_REJECT     = 3'd4,
        CMD_PAUSE      = 3'd5,
        CMD_RESUME     = 3'd6,
        CMD_STOP       = 3'd7
    } cmd_e_t;

    // per-page job record, 38 bits
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] height;
        logic [SIZE_W-1:0] width;
        logic [ROT_W-1:0]  rotation;
        logic [KIND_W-1:0] kind;
    } job_params_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic unlink;
        logic push;
        logic take;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_e_t op;
        logic   add_skip;
        logic   marked;
        logic   take_ok;
    } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/clq_ctrl.sv
// sequencing state machine for the coalescing lifo job queue
// depends on clq_pkg; drives clq_dp through clq_pkg::ctrl_cmd_t
`default_nettype none

module clq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire clq_pkg::ctrl_stat_t stat,
    output clq_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_UNLINK = 6'b000100,
        S_PUSH   = 6'b001000,
        S_TAKE   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                unique case (stat.op)
                    clq_pkg::CMD_ADD: begin
                        if (stat.add_skip)    state_next = S_DONE;
                        else if (stat.marked) state_next = S_UNLINK;
                        else                  state_next = S_PUSH;
                    end
                    clq_pkg::CMD_TAKE: begin
                        state_next = stat.take_ok ? S_TAKE : S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_UNLINK: state_next = S_PUSH;
            S_PUSH:   state_next = S_DONE;
            S_TAKE:   state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.capture  = s_valid && (state_reg == S_IDLE);
        cmd.exec     = (state_reg == S_EXEC);
        cmd.unlink   = (state_reg == S_UNLINK);
        cmd.push     = (state_reg == S_PUSH);
        cmd.take     = (state_reg == S_TAKE);
        cmd.load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/clq_dp.sv
// datapath of the coalescing lifo job queue: link and record memories,
// queue pointers, current job, flags and the result register; uses clq_pkg
`default_nettype none

module clq_dp #(
    parameter int PAGE_COUNT = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire clq_pkg::ctrl_cmd_t                  cmd,
    output clq_pkg::ctrl_stat_t                      stat,
    input  wire logic [2:0]                          s_cmd,
    input  wire logic [clq_pkg::PAGE_W-1:0]          s_page,
    input  wire logic [clq_pkg::KIND_W-1:0]          s_job_kind,
    input  wire logic [clq_pkg::ROT_W-1:0]           s_rotation,
    input  wire logic [clq_pkg::SIZE_W-1:0]          s_target_width,
    input  wire logic [clq_pkg::SIZE_W-1:0]          s_target_height,
    input  wire logic [clq_pkg::MODE_W-1:0]          s_view_mode,
    input  wire logic [clq_pkg::SETTINGS_W-1:0]      s_settings_tag,
    output logic                                     m_job_valid,
    output logic [clq_pkg::PAGE_W-1:0]               m_job_page,
    output logic [clq_pkg::KIND_W-1:0]               m_job_kind_out,
    output logic [clq_pkg::ROT_W-1:0]                m_job_rotation,
    output logic [clq_pkg::SIZE_W-1:0]               m_job_width,
    output logic [clq_pkg::SIZE_W-1:0]               m_job_height,
    output logic [clq_pkg::MODE_W-1:0]               m_job_mode,
    output logic [clq_pkg::SETTINGS_W-1:0]           m_job_settings,
    output logic                                     m_notify_owner,
    output logic                                     m_work_ready,
    output logic [clq_pkg::COUNT_W-1:0]              m_pending_count
);

    // pages above the page field's span can never be addressed
    localparam int PAGE_SPAN = 2 ** clq_pkg::PAGE_W;
    localparam int DEPTH     = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;
    localparam int PW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);

    // captured command
    clq_pkg::cmd_e_t                   op_reg;
    logic [clq_pkg::PAGE_W-1:0]        page_reg;
    clq_pkg::job_params_t              params_reg;
    logic [clq_pkg::SETTINGS_W-1:0]    settings_reg;

    // link and record memories
    logic [PW-1:0]                     next_mem     [DEPTH];
    logic [PW-1:0]                     prev_mem     [DEPTH];
    clq_pkg::job_params_t              params_mem   [DEPTH];
    logic [clq_pkg::SETTINGS_W-1:0]    settings_mem [DEPTH];

    logic [PW-1:0]                     nxt_rd_reg;
    logic [PW-1:0]                     prv_rd_reg;
    clq_pkg::job_params_t              par_rd_reg;
    logic [clq_pkg::SETTINGS_W-1:0]    set_rd_reg;

    // queue and job state
    logic [DEPTH-1:0]                  mark_reg, mark_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [PW-1:0]                     front_reg, front_next;
    logic [PW-1:0]                     back_reg, back_next;
    logic                              cur_valid_reg, cur_valid_next;
    logic [PW-1:0]                     cur_page_reg, cur_page_next;
    clq_pkg::job_params_t              cur_params_reg, cur_params_next;
    logic [clq_pkg::SETTINGS_W-1:0]    cur_settings_reg, cur_settings_next;
    logic                              reject_reg, reject_next;
    logic                              paused_reg, paused_next;
    logic                              stopped_reg, stopped_next;
    logic                              job_valid_reg, job_valid_next;
    logic                              notify_reg, notify_next;

    clq_pkg::job_params_t              in_params;
    logic [clq_pkg::SETTINGS_W-1:0]    in_settings;
    logic [PW-1:0]                     pidx;
    logic [PW-1:0]                     raddr;
    logic                              in_range;
    logic                              dup;
    logic                              unlink_mid;

    // non-render jobs keep only their kind
    always_comb begin
        in_params      = '0;
        in_settings    = '0;
        in_params.kind = s_job_kind;
        if (s_job_kind == clq_pkg::KIND_RENDER) begin
            in_params.rotation = s_rotation;
            in_params.width    = s_target_width;
            in_params.height   = s_target_height;
            in_params.mode     = s_view_mode;
            in_settings        = s_settings_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= clq_pkg::cmd_e_t'(s_cmd);
            page_reg     <= s_page;
            params_reg   <= in_params;
            settings_reg <= in_settings;
        end
    end

    assign pidx     = PW'(page_reg);
    assign in_range = {{(32 - clq_pkg::PAGE_W){1'b0}}, page_reg} < 32'(PAGE_COUNT);
    assign dup      = cur_valid_reg && (cur_page_reg == pidx)
                   && (cur_params_reg.kind == clq_pkg::KIND_RENDER)
                   && (params_reg.kind == clq_pkg::KIND_RENDER)
                   && (cur_params_reg == params_reg)
                   && (cur_settings_reg == settings_reg);

    always_comb begin
        stat.op       = op_reg;
        stat.add_skip = !in_range || dup;
        stat.marked   = mark_reg[pidx];
        stat.take_ok  = !stopped_reg && (count_reg != '0);
    end

    assign raddr      = (op_reg == clq_pkg::CMD_TAKE) ? front_reg : pidx;
    assign unlink_mid = (count_reg > CW'(1)) && (pidx != front_reg) && (pidx != back_reg);

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            nxt_rd_reg <= next_mem[raddr];
            prv_rd_reg <= prev_mem[raddr];
            par_rd_reg <= params_mem[raddr];
            set_rd_reg <= settings_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.unlink && unlink_mid) begin
            next_mem[prv_rd_reg] <= nxt_rd_reg;
        end else if (cmd.push && (count_reg != '0)) begin
            next_mem[pidx] <= front_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.unlink && unlink_mid) begin
            prev_mem[nxt_rd_reg] <= prv_rd_reg;
        end else if (cmd.push && (count_reg != '0)) begin
            prev_mem[front_reg] <= pidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            params_mem[pidx]   <= params_reg;
            settings_mem[pidx] <= settings_reg;
        end
    end

    always_comb begin
        mark_next         = mark_reg;
        count_next        = count_reg;
        front_next        = front_reg;
        back_next         = back_reg;
        cur_valid_next    = cur_valid_reg;
        cur_page_next     = cur_page_reg;
        cur_params_next   = cur_params_reg;
        cur_settings_next = cur_settings_reg;
        reject_next       = reject_reg;
        paused_next       = paused_reg;
        stopped_next      = stopped_reg;
        job_valid_next    = job_valid_reg;
        notify_next       = notify_reg;

        if (cmd.exec) begin
            job_valid_next = 1'b0;
            notify_next    = 1'b0;
            case (op_reg)
                clq_pkg::CMD_FINISH: begin
                    if (cur_valid_reg) begin
                        notify_next    = !reject_reg
                                      && (cur_params_reg.kind != clq_pkg::KIND_CLEANUP);
                        cur_valid_next = 1'b0;
                    end
                end
                clq_pkg::CMD_REMOVE_ALL: begin
                    mark_next  = '0;
                    count_next = '0;
                end
                clq_pkg::CMD_REJECT: begin
                    if (cur_valid_reg) reject_next = 1'b1;
                end
                clq_pkg::CMD_PAUSE:  paused_next = 1'b1;
                clq_pkg::CMD_RESUME: paused_next = 1'b0;
                clq_pkg::CMD_STOP: begin
                    mark_next    = '0;
                    count_next   = '0;
                    reject_next  = 1'b1;
                    paused_next  = 1'b1;
                    stopped_next = 1'b1;
                end
                default: ;
            endcase
        end

        if (cmd.unlink) begin
            if (count_reg > CW'(1)) begin
                if (pidx == front_reg)     front_next = nxt_rd_reg;
                else if (pidx == back_reg) back_next  = prv_rd_reg;
            end
            mark_next[pidx] = 1'b0;
            count_next      = count_reg - CW'(1);
        end

        if (cmd.push) begin
            if (count_reg == '0) back_next = pidx;
            front_next      = pidx;
            mark_next[pidx] = 1'b1;
            count_next      = count_reg + CW'(1);
        end

        if (cmd.take) begin
            if (count_reg > CW'(1)) front_next = nxt_rd_reg;
            mark_next[front_reg] = 1'b0;
            count_next           = count_reg - CW'(1);
            reject_next          = 1'b0;
            cur_valid_next       = 1'b1;
            cur_page_next        = front_reg;
            cur_params_next      = par_rd_reg;
            cur_settings_next    = set_rd_reg;
            job_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg      <= '0;
            count_reg     <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            cur_valid_reg <= 1'b0;
            reject_reg    <= 1'b0;
            paused_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
            job_valid_reg <= 1'b0;
            notify_reg    <= 1'b0;
        end else begin
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            cur_valid_reg <= cur_valid_next;
            reject_reg    <= reject_next;
            paused_reg    <= paused_next;
            stopped_reg   <= stopped_next;
            job_valid_reg <= job_valid_next;
            notify_reg    <= notify_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_page_reg     <= cur_page_next;
        cur_params_reg   <= cur_params_next;
        cur_settings_reg <= cur_settings_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_job_valid     <= job_valid_reg;
            m_job_page      <= job_valid_reg ? clq_pkg::PAGE_W'(cur_page_reg) : '0;
            m_job_kind_out  <= job_valid_reg ? cur_params_reg.kind : '0;
            m_job_rotation  <= job_valid_reg ? cur_params_reg.rotation : '0;
            m_job_width     <= job_valid_reg ? cur_params_reg.width : '0;
            m_job_height    <= job_valid_reg ? cur_params_reg.height : '0;
            m_job_mode      <= job_valid_reg ? cur_params_reg.mode : '0;
            m_job_settings  <= job_valid_reg ? cur_settings_reg : '0;
            m_notify_owner  <= notify_reg;
            m_work_ready    <= (count_reg != '0) && !paused_reg;
            m_pending_count <= clq_pkg::COUNT_W'(count_reg);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/coalescing_lifo_job_queue.sv
// top level of the coalescing lifo job queue
// depends on clq_pkg, clq_ctrl and clq_dp
`default_nettype none

// newest-first job queue with at most one pending job per page. every
// input beat carries one command and yields exactly one result beat with
// the pending count and work_ready after the command; take also returns
// the dispatched job, finish returns notify_owner. commands are handled
// one at a time, each ending in the done step: take-less commands (take
// on an empty or stopped queue, finish, remove all, reject, pause, resume,
// stop, and an add that is dropped) go through exec, take through exec
// and take, an add of a page not yet queued through exec and push, and
// an add that first has to unlink the page's older job through exec,
// unlink and push, set by the single read port of the link memories: an
// unlink is a read followed by a write of the neighbors' links, and the
// push needs the link port again. the result stage holds one finished
// beat; a new command is accepted while it waits, and the command after
// that waits only if the result is still not taken. link and job record
// memories need no clearing pass after reset: they are read only for
// queued pages, and the queued marks are flip-flops that reset and remove
// all clear at once. pages at or above PAGE_COUNT are ignored by add.

module coalescing_lifo_job_queue #(
    parameter int PAGE_COUNT = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [2:0]                          s_cmd,
    input  wire logic [clq_pkg::PAGE_W-1:0]          s_page,
    input  wire logic [clq_pkg::KIND_W-1:0]          s_job_kind,
    input  wire logic [clq_pkg::ROT_W-1:0]           s_rotation,
    input  wire logic [clq_pkg::SIZE_W-1:0]          s_target_width,
    input  wire logic [clq_pkg::SIZE_W-1:0]          s_target_height,
    input  wire logic [clq_pkg::MODE_W-1:0]          s_view_mode,
    input  wire logic [clq_pkg::SETTINGS_W-1:0]      s_settings_tag,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_job_valid,
    output logic [clq_pkg::PAGE_W-1:0]               m_job_page,
    output logic [clq_pkg::KIND_W-1:0]               m_job_kind_out,
    output logic [clq_pkg::ROT_W-1:0]                m_job_rotation,
    output logic [clq_pkg::SIZE_W-1:0]               m_job_width,
    output logic [clq_pkg::SIZE_W-1:0]               m_job_height,
    output logic [clq_pkg::MODE_W-1:0]               m_job_mode,
    output logic [clq_pkg::SETTINGS_W-1:0]           m_job_settings,
    output logic                                     m_notify_owner,
    output logic                                     m_work_ready,
    output logic [clq_pkg::COUNT_W-1:0]              m_pending_count
);

    // command and status between sequencer and datapath
    clq_pkg::ctrl_cmd_t  ctrl_cmd;
    clq_pkg::ctrl_stat_t ctrl_stat;

    clq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (ctrl_stat),
        .cmd     (ctrl_cmd)
    );

    clq_dp #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctrl_cmd),
        .stat            (ctrl_stat),
        .s_cmd           (s_cmd),
        .s_page          (s_page),
        .s_job_kind      (s_job_kind),
        .s_rotation      (s_rotation),
        .s_target_width  (s_target_width),
        .s_target_height (s_target_height),
        .s_view_mode     (s_view_mode),
        .s_settings_tag  (s_settings_tag),
        .m_job_valid     (m_job_valid),
        .m_job_page      (m_job_page),
        .m_job_kind_out  (m_job_kind_out),
        .m_job_rotation  (m_job_rotation),
        .m_job_width     (m_job_width),
        .m_job_height    (m_job_height),
        .m_job_mode      (m_job_mode),
        .m_job_settings  (m_job_settings),
        .m_notify_owner  (m_notify_owner),
        .m_work_ready    (m_work_ready),
        .m_pending_count (m_pending_count)
    );

    // one command in flight: an accepted beat drops s_ready
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a command is in flight");

    // the sequencer issues at most one datapath step per cycle
    a_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl_cmd.exec, ctrl_cmd.unlink, ctrl_cmd.push, ctrl_cmd.take}))
        else $error("overlapping datapath steps");

    // a dispatched job never comes with a finish notification
    a_take_not_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_job_valid && m_notify_owner))
        else $error("job and notify in the same result beat");

    // work_ready implies something is pending
    a_ready_needs_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_work_ready) |-> (m_pending_count != '0))
        else $error("work_ready with empty queue");

endmodule

`default_nettype wire

FILE: tb/sv/clq_reply_checker.sv
// reply checker for the coalescing lifo job queue: watches both channels,
// predicts each reply from the accepted command beats and compares
// depends on clq_pkg
`timescale 1ns / 1ps

module clq_reply_checker #(
    parameter int PAGE_COUNT = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [2:0]                     s_cmd,
    input  wire logic [clq_pkg::PAGE_W-1:0]     s_page,
    input  wire logic [clq_pkg::KIND_W-1:0]     s_job_kind,
    input  wire logic [clq_pkg::ROT_W-1:0]      s_rotation,
    input  wire logic [clq_pkg::SIZE_W-1:0]     s_target_width,
    input  wire logic [clq_pkg::SIZE_W-1:0]     s_target_height,
    input  wire logic [clq_pkg::MODE_W-1:0]     s_view_mode,
    input  wire logic [clq_pkg::SETTINGS_W-1:0] s_settings_tag,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic                           m_job_valid,
    input  wire logic [clq_pkg::PAGE_W-1:0]     m_job_page,
    input  wire logic [clq_pkg::KIND_W-1:0]     m_job_kind_out,
    input  wire logic [clq_pkg::ROT_W-1:0]      m_job_rotation,
    input  wire logic [clq_pkg::SIZE_W-1:0]     m_job_width,
    input  wire logic [clq_pkg::SIZE_W-1:0]     m_job_height,
    input  wire logic [clq_pkg::MODE_W-1:0]     m_job_mode,
    input  wire logic [clq_pkg::SETTINGS_W-1:0] m_job_settings,
    input  wire logic                           m_notify_owner,
    input  wire logic                           m_work_ready,
    input  wire logic [clq_pkg::COUNT_W-1:0]    m_pending_count,
    output int                                  fail_count,
    output int                                  beats_owed
);

    typedef struct packed {
        logic                           job_valid;
        logic [clq_pkg::PAGE_W-1:0]     page;
        logic [clq_pkg::KIND_W-1:0]     kind;
        logic [clq_pkg::ROT_W-1:0]      rotation;
        logic [clq_pkg::SIZE_W-1:0]     width;
        logic [clq_pkg::SIZE_W-1:0]     height;
        logic [clq_pkg::MODE_W-1:0]     mode;
        logic [clq_pkg::SETTINGS_W-1:0] settings;
        logic                           notify_owner;
        logic                           work_ready;
        logic [clq_pkg::COUNT_W-1:0]    pending_count;
    } queue_reply_t;

    // shadow of the page list and the job in progress
    logic                           queued [PAGE_COUNT];
    logic [clq_pkg::PAGE_W-1:0]     next_pg [PAGE_COUNT];
    logic [clq_pkg::PAGE_W-1:0]     prev_pg [PAGE_COUNT];
    clq_pkg::job_params_t           page_rec [PAGE_COUNT];
    logic [clq_pkg::SETTINGS_W-1:0] page_set [PAGE_COUNT];
    logic [clq_pkg::PAGE_W-1:0]     head_pg;
    logic [clq_pkg::PAGE_W-1:0]     tail_pg;
    int                             depth;
    logic                           cur_valid;
    logic [clq_pkg::PAGE_W-1:0]     cur_pg;
    clq_pkg::job_params_t           cur_rec;
    logic [clq_pkg::SETTINGS_W-1:0] cur_set;
    logic                           rejected;
    logic                           paused;
    logic                           stopped;

    queue_reply_t replies_due [$];
    queue_reply_t want;

    function automatic void unlink_page(logic [clq_pkg::PAGE_W-1:0] pg);
        if (depth > 1) begin
            if (pg == head_pg) begin
                head_pg = next_pg[pg];
            end else if (pg == tail_pg) begin
                tail_pg = prev_pg[pg];
            end else begin
                next_pg[prev_pg[pg]] = next_pg[pg];
                prev_pg[next_pg[pg]] = prev_pg[pg];
            end
        end
        queued[pg] = 1'b0;
        depth--;
    endfunction

    function automatic void push_page(logic [clq_pkg::PAGE_W-1:0] pg);
        if (depth == 0) begin
            head_pg = pg;
            tail_pg = pg;
        end else begin
            next_pg[pg]      = head_pg;
            prev_pg[head_pg] = pg;
            head_pg          = pg;
        end
        queued[pg] = 1'b1;
        depth++;
    endfunction

    function automatic void clear_pages();
        foreach (queued[i]) queued[i] = 1'b0;
        depth = 0;
    endfunction

    function automatic void reset_queue();
        clear_pages();
        foreach (next_pg[i]) begin
            next_pg[i]  = '0;
            prev_pg[i]  = '0;
            page_rec[i] = '0;
            page_set[i] = '0;
        end
        head_pg   = '0;
        tail_pg   = '0;
        cur_valid = 1'b0;
        cur_pg    = '0;
        cur_rec   = '0;
        cur_set   = '0;
        rejected  = 1'b0;
        paused    = 1'b0;
        stopped   = 1'b0;
    endfunction

    // one command against the shadow state, returns the reply it causes
    function automatic queue_reply_t apply_command(clq_pkg::cmd_e_t op,
                                                   logic [clq_pkg::PAGE_W-1:0] pg,
                                                   clq_pkg::job_params_t req,
                                                   logic [clq_pkg::SETTINGS_W-1:0] req_set);
        queue_reply_t               r;
        logic [clq_pkg::KIND_W-1:0] k;
        logic [clq_pkg::PAGE_W-1:0] front;
        r = '0;
        k = req.kind;
        // only render jobs keep their parameters
        if (k != clq_pkg::KIND_RENDER) begin
            req      = '0;
            req.kind = k;
            req_set  = '0;
        end
        case (op)
            clq_pkg::CMD_ADD: begin
                if (int'(pg) < PAGE_COUNT &&
                    !(cur_valid && cur_pg == pg && cur_rec.kind == clq_pkg::KIND_RENDER &&
                      req.kind == clq_pkg::KIND_RENDER && cur_rec == req &&
                      cur_set == req_set)) begin
                    if (queued[pg]) unlink_page(pg);
                    page_rec[pg] = req;
                    page_set[pg] = req_set;
                    push_page(pg);
                end
            end
            clq_pkg::CMD_TAKE: begin
                if (!stopped && depth != 0) begin
                    front = head_pg;
                    unlink_page(front);
                    rejected  = 1'b0;
                    cur_valid = 1'b1;
                    cur_pg    = front;
                    cur_rec   = page_rec[front];
                    cur_set   = page_set[front];
                    r.job_valid = 1'b1;
                    r.page      = front;
                    r.kind      = cur_rec.kind;
                    r.rotation  = cur_rec.rotation;
                    r.width     = cur_rec.width;
                    r.height    = cur_rec.height;
                    r.mode      = cur_rec.mode;
                    r.settings  = cur_set;
                end
            end
            clq_pkg::CMD_FINISH: begin
                if (cur_valid) begin
                    r.notify_owner = !rejected && cur_rec.kind != clq_pkg::KIND_CLEANUP;
                    cur_valid      = 1'b0;
                end
            end
            clq_pkg::CMD_REMOVE_ALL: clear_pages();
            clq_pkg::CMD_REJECT: begin
                if (cur_valid) rejected = 1'b1;
            end
            clq_pkg::CMD_PAUSE:  paused = 1'b1;
            clq_pkg::CMD_RESUME: paused = 1'b0;
            default: begin
                clear_pages();
                rejected = 1'b1;
                paused   = 1'b1;
                stopped  = 1'b1;
            end
        endcase
        r.work_ready    = depth != 0 && !paused;
        r.pending_count = clq_pkg::COUNT_W'(depth);
        return r;
    endfunction

    task automatic check_field(string fname, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, fname, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_queue();
            replies_due.delete();
            fail_count = 0;
            beats_owed = 0;
        end else begin
            // a reply beat always belongs to an earlier command beat
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply beat with no command outstanding", $time);
                    fail_count++;
                end else begin
                    want = replies_due[0];
                    replies_due.delete(0);
                    check_field("job_valid", 32'(want.job_valid), 32'(m_job_valid));
                    check_field("job_page", 32'(want.page), 32'(m_job_page));
                    check_field("job_kind", 32'(want.kind), 32'(m_job_kind_out));
                    check_field("job_rotation", 32'(want.rotation), 32'(m_job_rotation));
                    check_field("job_width", 32'(want.width), 32'(m_job_width));
                    check_field("job_height", 32'(want.height), 32'(m_job_height));
                    check_field("job_mode", 32'(want.mode), 32'(m_job_mode));
                    check_field("job_settings", want.settings, m_job_settings);
                    check_field("notify_owner", 32'(want.notify_owner),
                                32'(m_notify_owner));
                    check_field("work_ready", 32'(want.work_ready), 32'(m_work_ready));
                    check_field("pending_count", 32'(want.pending_count),
                                32'(m_pending_count));
                end
            end
            if (s_valid && s_ready)
                replies_due.push_back(apply_command(clq_pkg::cmd_e_t'(s_cmd), s_page,
                    '{mode: s_view_mode, height: s_target_height, width: s_target_width,
                      rotation: s_rotation, kind: s_job_kind},
                    s_settings_tag));
            beats_owed = replies_due.size();
        end
    end

endmodule

FILE: tb/sv/tb_coalescing_lifo_job_queue.sv
// testbench top for the coalescing lifo job queue: drives command beats,
// stalls the reply side and gives the verdict
// depends on clq_pkg, clq_reply_checker and coalescing_lifo_job_queue
`timescale 1ns / 1ps

module tb_coalescing_lifo_job_queue;

    localparam int PAGE_COUNT   = 64;
    localparam int RANDOM_BEATS = 960;
    localparam int HISTORY      = 8;

    // one job as offered on the command channel
    typedef struct packed {
        logic [clq_pkg::PAGE_W-1:0]     page;
        logic [clq_pkg::KIND_W-1:0]     kind;
        logic [clq_pkg::ROT_W-1:0]      rotation;
        logic [clq_pkg::SIZE_W-1:0]     width;
        logic [clq_pkg::SIZE_W-1:0]     height;
        logic [clq_pkg::MODE_W-1:0]     mode;
        logic [clq_pkg::SETTINGS_W-1:0] settings;
    } job_req_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [2:0]                     s_cmd;
    logic [clq_pkg::PAGE_W-1:0]     s_page;
    logic [clq_pkg::KIND_W-1:0]     s_job_kind;
    logic [clq_pkg::ROT_W-1:0]      s_rotation;
    logic [clq_pkg::SIZE_W-1:0]     s_target_width;
    logic [clq_pkg::SIZE_W-1:0]     s_target_height;
    logic [clq_pkg::MODE_W-1:0]     s_view_mode;
    logic [clq_pkg::SETTINGS_W-1:0] s_settings_tag;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_job_valid;
    logic [clq_pkg::PAGE_W-1:0]     m_job_page;
    logic [clq_pkg::KIND_W-1:0]     m_job_kind_out;
    logic [clq_pkg::ROT_W-1:0]      m_job_rotation;
    logic [clq_pkg::SIZE_W-1:0]     m_job_width;
    logic [clq_pkg::SIZE_W-1:0]     m_job_height;
    logic [clq_pkg::MODE_W-1:0]     m_job_mode;
    logic [clq_pkg::SETTINGS_W-1:0] m_job_settings;
    logic                           m_notify_owner;
    logic                           m_work_ready;
    logic [clq_pkg::COUNT_W-1:0]    m_pending_count;
    int                             fail_count;
    int                             beats_owed;

    // shared between the sender and the reply-side process
    bit idle_en     = 1'b1;
    int hold_cycles = 0;

    // recent adds, replayed so that a job equal to the one in progress
    // or to a queued one comes back now and then
    job_req_t recent_adds [HISTORY];
    int       add_slot = 0;

    coalescing_lifo_job_queue #(.PAGE_COUNT(PAGE_COUNT)) u_top (.*);

    clq_reply_checker #(.PAGE_COUNT(PAGE_COUNT)) u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // reply side: random stalls, plus a long hold-off on request so the
    // result stage fills and the command side backs up
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (idle_en) begin
                m_ready <= ($urandom_range(99, 0) >= 20);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic job_req_t mk_job(logic [clq_pkg::PAGE_W-1:0] pg,
                                        logic [clq_pkg::KIND_W-1:0] k,
                                        logic [clq_pkg::ROT_W-1:0] rot,
                                        logic [clq_pkg::SIZE_W-1:0] w,
                                        logic [clq_pkg::SIZE_W-1:0] h,
                                        logic [clq_pkg::MODE_W-1:0] md,
                                        logic [clq_pkg::SETTINGS_W-1:0] st);
        job_req_t j;
        j.page     = pg;
        j.kind     = k;
        j.rotation = rot;
        j.width    = w;
        j.height   = h;
        j.mode     = md;
        j.settings = st;
        return j;
    endfunction

    // mostly a few hot pages so adds coalesce; sizes and tags lean toward
    // the extremes and a small pool of values so equal jobs show up
    function automatic job_req_t random_job();
        job_req_t j;
        j.page     = ($urandom_range(9, 0) < 7) ? clq_pkg::PAGE_W'($urandom_range(7, 0))
                                                : clq_pkg::PAGE_W'($urandom_range(63, 0));
        j.kind     = $urandom_range(1, 0) ? clq_pkg::KIND_RENDER
                                          : clq_pkg::KIND_W'($urandom_range(3, 0));
        j.rotation = clq_pkg::ROT_W'($urandom_range(3, 0));
        j.width    = ($urandom_range(4, 0) == 0) ? ($urandom_range(1, 0) ? 16'hFFFF : 16'h0)
                                                 : clq_pkg::SIZE_W'($urandom);
        j.height   = ($urandom_range(4, 0) == 0) ? ($urandom_range(1, 0) ? 16'hFFFF : 16'h0)
                                                 : clq_pkg::SIZE_W'($urandom);
        j.mode     = clq_pkg::MODE_W'($urandom_range(3, 0));
        j.settings = ($urandom_range(2, 0) == 0) ? clq_pkg::SETTINGS_W'($urandom_range(3, 0))
                                                 : $urandom;
        return j;
    endfunction

    // offer one command beat and hold it until the block takes it; valid
    // stays high into the next beat unless a random gap is inserted
    task automatic send_beat(clq_pkg::cmd_e_t op, job_req_t j);
        @(negedge aclk);
        if (idle_en && $urandom_range(99, 0) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_cmd           <= op;
        s_page          <= j.page;
        s_job_kind      <= j.kind;
        s_rotation      <= j.rotation;
        s_target_width  <= j.width;
        s_target_height <= j.height;
        s_view_mode     <= j.mode;
        s_settings_tag  <= j.settings;
        s_valid         <= 1'b1;
        if (op == clq_pkg::CMD_ADD) begin
            recent_adds[add_slot] = j;
            add_slot = (add_slot + 1) % HISTORY;
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // random command mix; the payload of non-add commands is junk on purpose
    task automatic send_random(bit allow_stop);
        int unsigned sel;
        job_req_t    j;
        sel = $urandom_range(99, 0);
        j   = random_job();
        if (sel < 45) begin
            if ($urandom_range(3, 0) == 0) j = recent_adds[$urandom_range(HISTORY - 1, 0)];
            send_beat(clq_pkg::CMD_ADD, j);
        end else if (sel < 70) begin
            send_beat(clq_pkg::CMD_TAKE, j);
        end else if (sel < 81) begin
            send_beat(clq_pkg::CMD_FINISH, j);
        end else if (sel < 87) begin
            send_beat(clq_pkg::CMD_REJECT, j);
        end else if (sel < 92) begin
            send_beat(clq_pkg::CMD_PAUSE, j);
        end else if (sel < 97) begin
            send_beat(clq_pkg::CMD_RESUME, j);
        end else if (sel < 99 || !allow_stop) begin
            send_beat(clq_pkg::CMD_REMOVE_ALL, j);
        end else begin
            send_beat(clq_pkg::CMD_STOP, j);
        end
    endtask

    initial begin : stimulus
        int       order [PAGE_COUNT];
        int       pick;
        int       swap;
        job_req_t j;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_cmd           = clq_pkg::CMD_ADD;
        s_page          = '0;
        s_job_kind      = '0;
        s_rotation      = '0;
        s_target_width  = '0;
        s_target_height = '0;
        s_view_mode     = '0;
        s_settings_tag  = '0;
        foreach (recent_adds[i]) recent_adds[i] = random_job();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty-queue corners first
        send_beat(clq_pkg::CMD_TAKE, random_job());      // take on empty queue
        send_beat(clq_pkg::CMD_FINISH, random_job());    // finish with no current job
        send_beat(clq_pkg::CMD_REJECT, random_job());    // reject with no current job

        // fill with field extremes and every job kind; list ends up 42,7,5,63,0
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd0, clq_pkg::KIND_RENDER, 2'd3, 16'hFFFF,
                                           16'hFFFF, 2'd3, 32'hFFFF_FFFF));
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd63, clq_pkg::KIND_RENDER, 2'd0, 16'h0, 16'h0,
                                           2'd0, 32'h0));
        // non-render jobs carry junk that must be dropped
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd5, 2'd1, 2'd2, 16'h1234, 16'h5678, 2'd1,
                                           32'hDEAD_BEEF));
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd7, clq_pkg::KIND_CLEANUP, 2'd1, 16'hFFFF, 16'h0,
                                           2'd2, 32'h8000_0001));
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd42, 2'd2, 2'd3, 16'h00FF, 16'hFF00, 2'd3,
                                           32'h5555_AAAA));

        // re-adds: page in the middle, then at the front, then at the back
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd5, clq_pkg::KIND_RENDER, 2'd2, 16'd640, 16'd480,
                                           2'd1, 32'hA5A5_5A5A));
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd5, clq_pkg::KIND_RENDER, 2'd2, 16'd640, 16'd480,
                                           2'd1, 32'hA5A5_5A5A));
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd0, clq_pkg::KIND_RENDER, 2'd1, 16'd800, 16'd600,
                                           2'd2, 32'h0000_1234));

        // take page 0, then re-add the identical render job: dropped
        send_beat(clq_pkg::CMD_TAKE, random_job());
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd0, clq_pkg::KIND_RENDER, 2'd1, 16'd800, 16'd600,
                                           2'd2, 32'h0000_1234));
        // same page, other settings: queued again
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd0, clq_pkg::KIND_RENDER, 2'd1, 16'd800, 16'd600,
                                           2'd2, 32'h0000_1235));

        // take still works while paused, work_ready drops
        send_beat(clq_pkg::CMD_PAUSE, random_job());
        send_beat(clq_pkg::CMD_TAKE, random_job());
        send_beat(clq_pkg::CMD_RESUME, random_job());
        send_beat(clq_pkg::CMD_FINISH, random_job());    // plain finish, owner notified

        send_beat(clq_pkg::CMD_TAKE, random_job());      // page 5
        send_beat(clq_pkg::CMD_REJECT, random_job());
        send_beat(clq_pkg::CMD_FINISH, random_job());    // rejected, no notify
        send_beat(clq_pkg::CMD_TAKE, random_job());      // page 42, read info
        send_beat(clq_pkg::CMD_TAKE, random_job());      // page 7, cleanup
        send_beat(clq_pkg::CMD_FINISH, random_job());    // cleanup, no notify
        send_beat(clq_pkg::CMD_REMOVE_ALL, random_job());
        send_beat(clq_pkg::CMD_TAKE, random_job());      // queue empty again

        // random phase, no stop here since stop is sticky until reset
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == 300) idle_en = 1'b0;       // back-to-back stretch
            if (i == 450) idle_en = 1'b1;
            if (i == 600) hold_cycles = 400;    // reply side stalls long
            // queue every page once, in shuffled order, to reach a full list
            if (i == 800) begin
                foreach (order[k]) order[k] = k;
                for (int k = PAGE_COUNT - 1; k > 0; k--) begin
                    pick        = $urandom_range(k, 0);
                    swap        = order[k];
                    order[k]    = order[pick];
                    order[pick] = swap;
                end
                foreach (order[k]) begin
                    j      = random_job();
                    j.page = clq_pkg::PAGE_W'(order[k]);
                    send_beat(clq_pkg::CMD_ADD, j);
                end
            end
            send_random(1'b0);
        end

        // stop and what still works after it
        send_beat(clq_pkg::CMD_ADD, random_job());
        send_beat(clq_pkg::CMD_TAKE, random_job());
        send_beat(clq_pkg::CMD_STOP, random_job());
        send_beat(clq_pkg::CMD_TAKE, random_job());      // refused, queue empty
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd3, clq_pkg::KIND_RENDER, 2'd1, 16'd100, 16'd200,
                                           2'd3, 32'h77));
        send_beat(clq_pkg::CMD_ADD, mk_job(6'd9, 2'd1, 2'd0, 16'd0, 16'd0, 2'd0, 32'h0));
        send_beat(clq_pkg::CMD_TAKE, random_job());      // refused with jobs waiting
        send_beat(clq_pkg::CMD_RESUME, random_job());
        send_beat(clq_pkg::CMD_FINISH, random_job());
        send_beat(clq_pkg::CMD_REJECT, random_job());
        send_beat(clq_pkg::CMD_PAUSE, random_job());
        send_beat(clq_pkg::CMD_REMOVE_ALL, random_job());
        for (int i = 0; i < 40; i++) send_random(1'b1);

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then a quiet tail to catch stray reply beats
        while (beats_owed != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/clq_pkg.sv
rtl/clq_ctrl.sv
rtl/clq_dp.sv
rtl/coalescing_lifo_job_queue.sv
tb/sv/clq_reply_checker.sv
tb/sv/tb_coalescing_lifo_job_queue.sv
